### hdl/surface_std_deviation_accumulator_assert.svh
// Assertion macros used by the block's top module.
`ifndef SURFACE_STD_DEVIATION_ACCUMULATOR_ASSERT_SVH
`define SURFACE_STD_DEVIATION_ACCUMULATOR_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define SDA_ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// Implication whose consequence is checked in the following cycle.
`define SDA_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

### hdl/sda_pkg.sv
package sda_pkg;
   localparam int unsigned ValW   = 24;
   localparam int unsigned WgtW   = 17;
   localparam int unsigned CntW   = 21;
   localparam int unsigned SumW   = 64;
   localparam int unsigned Lanes  = 3;
   localparam int unsigned MaxFacesDefault = 1048576;
   localparam logic [WgtW-1:0] WgtOne = 17'h10000;

   localparam logic [1:0] RegMeanX = 2'd0;
   localparam logic [1:0] RegMeanY = 2'd1;
   localparam logic [1:0] RegMeanZ = 2'd2;

   typedef enum logic [1:0] {
      ST_ACCUM,
      ST_DIV,
      ST_SQRT,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_DIV,
      F_SQRT
   } fin_state_type;
endpackage

### hdl/sda_if.sv
interface sda_req_if;
   logic                         valid;
   logic                         ready;
   logic signed [sda_pkg::ValW-1:0] left_x;
   logic signed [sda_pkg::ValW-1:0] left_y;
   logic signed [sda_pkg::ValW-1:0] left_z;
   logic signed [sda_pkg::ValW-1:0] right_x;
   logic signed [sda_pkg::ValW-1:0] right_y;
   logic signed [sda_pkg::ValW-1:0] right_z;
   logic [sda_pkg::WgtW-1:0]     weight;
   logic                         last_face;
   modport source (output valid, left_x, left_y, left_z, right_x, right_y, right_z,
                   weight, last_face, input ready);
   modport sink (input valid, left_x, left_y, left_z, right_x, right_y, right_z,
                 weight, last_face, output ready);
endinterface

interface sda_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [sda_pkg::ValW-1:0]  dev_x;
   logic [sda_pkg::ValW-1:0]  dev_y;
   logic [sda_pkg::ValW-1:0]  dev_z;
   logic [sda_pkg::CntW-1:0]  face_total;
   modport source (output valid, dev_x, dev_y, dev_z, face_total, input ready);
   modport sink (input valid, dev_x, dev_y, dev_z, face_total, output ready);
endinterface

interface sda_csr_if;
   logic                      valid;
   logic                      ready;
   logic [1:0]                index;
   logic [sda_pkg::ValW-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### hdl/sda_lane.sv
// One component: interpolate, subtract mean, square, saturating accumulate.
// Two register stages: product sums, then square/accumulate.
module sda_lane (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_vld,
   input  logic                           clear,
   input  logic signed [sda_pkg::ValW-1:0] left,
   input  logic signed [sda_pkg::ValW-1:0] right,
   input  logic [sda_pkg::WgtW-1:0]       weight,
   input  logic signed [sda_pkg::ValW-1:0] mean,
   output logic [sda_pkg::SumW-1:0]       sum
);
   logic signed [43:0] acc_ff, acc_in;
   logic signed [sda_pkg::ValW-1:0] mean_ff;
   logic               vld_ff;
   logic [sda_pkg::SumW-1:0] sum_ff, sum_in;
   logic signed [27:0] face;
   logic signed [25:0] diff;
   logic [24:0]        mag;
   logic [49:0]        sq;
   logic [sda_pkg::SumW:0] add;

   always_comb begin
      acc_in = 44'(left * $signed({1'b0, weight}))
             + 44'(right * $signed({1'b0, sda_pkg::WgtOne - weight}));
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      mean_ff <= mean;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= in_vld;
      end
   end

   always_comb begin
      face = 28'((acc_ff + 44'sd32768) >>> 16);
      diff = 26'(face) - 26'(mean_ff);
      mag  = diff[25] ? 25'(-diff) : 25'(diff);
      sq   = 50'(mag) * 50'(mag);
      add  = {1'b0, sum_ff} + 65'(sq);
      sum_in = sum_ff;
      if (vld_ff) begin
         sum_in = add[sda_pkg::SumW] ? '1 : add[sda_pkg::SumW-1:0];
      end
      if (clear) begin
         sum_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

   assign sum = sum_ff;
endmodule

### hdl/sda_finish.sv
// Merge stage: restoring divide of sum by count, then bit-pair square root,
// shared by the three lanes one after another.
module sda_finish (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [sda_pkg::SumW-1:0] dividend,
   input  logic [sda_pkg::CntW+3:0] divisor,
   output logic                     done,
   output logic [sda_pkg::ValW-1:0] root
);
   localparam int unsigned DW = sda_pkg::CntW + 4;
   sda_pkg::fin_state_type st_ff, st_in;
   logic [6:0] cnt_ff, cnt_in;
   logic [sda_pkg::SumW-1:0] q_ff, q_in;
   logic [DW:0] r_ff, r_in;
   logic [DW-1:0] dvs_ff;
   logic [33:0] sr_ff, sr_in;
   logic [31:0] res_ff, res_in;
   logic [DW:0] rsh;
   logic [33:0] trial;
   logic [33:0] srsh;

   always_comb begin
      st_in = st_ff; cnt_in = cnt_ff; q_in = q_ff; r_in = r_ff;
      sr_in = sr_ff; res_in = res_ff;
      rsh = {r_ff[DW-1:0], q_ff[sda_pkg::SumW-1]};
      srsh = {sr_ff[31:0], q_ff[sda_pkg::SumW-1:sda_pkg::SumW-2]};
      trial = {res_ff, 2'b01};
      unique case (st_ff)
         sda_pkg::F_IDLE: begin
            if (start) begin
               st_in = sda_pkg::F_DIV; cnt_in = '0; q_in = dividend; r_in = '0;
            end
         end
         sda_pkg::F_DIV: begin
            if (rsh >= {1'b0, dvs_ff}) begin
               r_in = rsh - {1'b0, dvs_ff};
               q_in = {q_ff[sda_pkg::SumW-2:0], 1'b1};
            end else begin
               r_in = rsh;
               q_in = {q_ff[sda_pkg::SumW-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd63) begin
               st_in = sda_pkg::F_SQRT; cnt_in = '0; sr_in = '0; res_in = '0;
            end
         end
         sda_pkg::F_SQRT: begin
            q_in = {q_ff[sda_pkg::SumW-3:0], 2'b00};
            if (srsh >= trial) begin
               sr_in = srsh - trial;
               res_in = {res_ff[30:0], 1'b1};
            end else begin
               sr_in = srsh;
               res_in = {res_ff[30:0], 1'b0};
            end
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd31) begin
               st_in = sda_pkg::F_IDLE;
            end
         end
         default: st_in = sda_pkg::F_IDLE;
      endcase
   end

   assign done = (st_ff == sda_pkg::F_SQRT) && (cnt_ff == 7'd31);

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= sda_pkg::F_IDLE;
      end else begin
         st_ff <= st_in;
      end
      cnt_ff <= cnt_in; q_ff <= q_in; r_ff <= r_in; sr_ff <= sr_in; res_ff <= res_in;
      if (start) begin
         dvs_ff <= divisor;
      end
   end

   // done coincides with last bit of res_in
   assign root = (|res_in[31:sda_pkg::ValW]) ? '1 : res_in[sda_pkg::ValW-1:0];
endmodule

### hdl/surface_std_deviation_accumulator.sv
// After an item marked last is accepted, the two lane stages drain, then for each
// component the shared finish unit takes a start, a divide and a square root.
// Throughput: one face per cycle while accumulating; after a last face the input
// is held until the three results are ready, longer if the previous result is
// not yet taken.
// Reset (synchronous) clears means, sums, face count and the result valid.
module surface_std_deviation_accumulator #(
   parameter int unsigned MAX_FACES = sda_pkg::MaxFacesDefault
) (
   input logic clock,
   input logic reset,
   sda_req_if.sink   req,
   sda_rsp_if.source rsp,
   sda_csr_if.sink   csr
);
   localparam int unsigned CW = sda_pkg::CntW + 4;
   sda_pkg::state_type st_ff, st_in;
   logic signed [sda_pkg::ValW-1:0] mean_ff [sda_pkg::Lanes];
   logic [CW-1:0] count_ff, count_in;
   logic [sda_pkg::SumW-1:0] sums [sda_pkg::Lanes];
   logic [1:0] lane_ff, lane_in;
   logic [1:0] drain_ff, drain_in;
   logic [sda_pkg::ValW-1:0] dev_ff [sda_pkg::Lanes];
   logic [sda_pkg::ValW-1:0] out_ff [sda_pkg::Lanes];
   logic [sda_pkg::CntW-1:0] total_ff;
   logic rvld_ff, rvld_in;
   logic acc, take, clear, fin_start, fin_done, out_go;
   logic [sda_pkg::WgtW-1:0] wgt;
   logic [sda_pkg::ValW-1:0] fin_root;
   logic [CW-1:0] divisor;

   assign wgt  = (req.weight > sda_pkg::WgtOne) ? sda_pkg::WgtOne : req.weight;
   assign acc  = req.valid && req.ready;
   assign take = acc && (count_ff < CW'(MAX_FACES));
   assign csr.ready = 1'b1;
   assign req.ready = (st_ff == sda_pkg::ST_ACCUM);
   // output register free this cycle
   assign out_go = !rvld_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mean_ff[0] <= '0; mean_ff[1] <= '0; mean_ff[2] <= '0;
      end else if (csr.valid) begin
         unique case (csr.index)
            sda_pkg::RegMeanX: mean_ff[0] <= csr.data;
            sda_pkg::RegMeanY: mean_ff[1] <= csr.data;
            sda_pkg::RegMeanZ: mean_ff[2] <= csr.data;
            default: ;
         endcase
      end
   end

   sda_lane u_lane_x (.clock, .reset, .in_vld(take), .clear, .left(req.left_x),
      .right(req.right_x), .weight(wgt), .mean(mean_ff[0]), .sum(sums[0]));
   sda_lane u_lane_y (.clock, .reset, .in_vld(take), .clear, .left(req.left_y),
      .right(req.right_y), .weight(wgt), .mean(mean_ff[1]), .sum(sums[1]));
   sda_lane u_lane_z (.clock, .reset, .in_vld(take), .clear, .left(req.left_z),
      .right(req.right_z), .weight(wgt), .mean(mean_ff[2]), .sum(sums[2]));

   assign divisor = (count_ff == '0) ? CW'(1) : count_ff;

   sda_finish u_finish (.clock, .reset, .start(fin_start), .dividend(sums[lane_ff]),
      .divisor(divisor), .done(fin_done), .root(fin_root));

   // next state
   always_comb begin
      st_in = st_ff; lane_in = lane_ff; drain_in = drain_ff;
      unique case (st_ff)
         sda_pkg::ST_ACCUM: begin
            if (acc && req.last_face) begin
               st_in = sda_pkg::ST_DIV; drain_in = 2'd2; lane_in = 2'd0;
            end
         end
         sda_pkg::ST_DIV: begin
            // let the lane pipeline land the last face
            if (drain_ff != 2'd0) begin
               drain_in = drain_ff - 2'd1;
            end else begin
               st_in = sda_pkg::ST_SQRT;
            end
         end
         sda_pkg::ST_SQRT: begin
            if (fin_done) begin
               if (lane_ff == 2'd2) begin
                  st_in = sda_pkg::ST_OUT;
               end else begin
                  lane_in = lane_ff + 2'd1;
                  st_in = sda_pkg::ST_DIV;
               end
            end
         end
         sda_pkg::ST_OUT: begin
            if (out_go) begin
               st_in = sda_pkg::ST_ACCUM;
            end
         end
         default: st_in = sda_pkg::ST_ACCUM;
      endcase
   end

   // outputs
   always_comb begin
      fin_start = 1'b0; clear = 1'b0; rvld_in = rvld_ff;
      count_in = count_ff;
      if (take) begin
         count_in = count_ff + CW'(1);
      end
      if (rsp.valid && rsp.ready) begin
         rvld_in = 1'b0;
      end
      unique case (st_ff)
         sda_pkg::ST_ACCUM: ;
         sda_pkg::ST_DIV: fin_start = (drain_ff == 2'd0);
         sda_pkg::ST_SQRT: ;
         sda_pkg::ST_OUT: begin
            if (out_go) begin
               clear = 1'b1; count_in = '0; rvld_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= sda_pkg::ST_ACCUM; count_ff <= '0; rvld_ff <= 1'b0;
         lane_ff <= '0; drain_ff <= '0;
      end else begin
         st_ff <= st_in; count_ff <= count_in; rvld_ff <= rvld_in;
         lane_ff <= lane_in; drain_ff <= drain_in;
      end
   end

   always_ff @(posedge clock) begin
      if (st_ff == sda_pkg::ST_SQRT && fin_done) begin
         dev_ff[lane_ff] <= fin_root;
      end
      if (st_ff == sda_pkg::ST_OUT && out_go) begin
         out_ff[0] <= dev_ff[0];
         out_ff[1] <= dev_ff[1];
         out_ff[2] <= dev_ff[2];
         total_ff  <= count_ff[sda_pkg::CntW-1:0];
      end
   end

   assign rsp.valid      = rvld_ff;
   assign rsp.dev_x      = out_ff[0];
   assign rsp.dev_y      = out_ff[1];
   assign rsp.dev_z      = out_ff[2];
   assign rsp.face_total = total_ff;

`include "surface_std_deviation_accumulator_assert.svh"
   `SDA_ASSERT_IMPLY(a_no_in_busy, clock, reset, st_ff != sda_pkg::ST_ACCUM, !req.ready)
   `SDA_ASSERT_IMPLY(a_cnt_cap, clock, reset, 1'b1, count_ff <= CW'(MAX_FACES))
   `SDA_ASSERT_NEXT(a_out_clears, clock, reset, st_ff == sda_pkg::ST_OUT && out_go,
      rvld_ff && count_ff == '0)
   `SDA_ASSERT_NEXT(a_rsp_hold, clock, reset, rvld_ff && !rsp.ready, rvld_ff)
   `SDA_ASSERT_IMPLY(a_lane_rng, clock, reset, 1'b1, lane_ff != 2'd3)
endmodule
